// ----- sv/multi_port_line_merge_fifo_core_defines.svh -----
// Assertion macros for the line merge FIFO core.
`ifndef MULTI_PORT_LINE_MERGE_FIFO_CORE_DEFINES_SVH
`define MULTI_PORT_LINE_MERGE_FIFO_CORE_DEFINES_SVH
`ifndef SYNTH
`define MPLM_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("mplm: same-cycle check failed");
`define MPLM_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("mplm: next-cycle check failed");
`else
`define MPLM_ASSERT_IMP(lbl, clk, rstn, a, b)
`define MPLM_ASSERT_NXT(lbl, clk, rstn, a, b)
`endif
`endif

// ----- sv/mplm_pkg.sv -----
// Shared types and constants for the line merge FIFO core.
`timescale 1ns / 1ps
`default_nettype none
package mplm_pkg;

    localparam int DEPTH_DEFAULT = 512;
    localparam int PORTS_DEFAULT = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int FREE_W        = 9;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // command handed from the front end to the back end
    typedef struct packed {
        logic              is_poll;
        logic              accepted;
        logic [7:0]        data;
        logic [FREE_W-1:0] free_space;
    } cmd_t;

endpackage
`default_nettype wire

// ----- sv/multi_port_line_merge_fifo_core.sv -----
// Line merge FIFO core: per-port byte rings merged line by line onto one stream.
// Each receive port owns a ring of DEPTH byte slots (one kept free, so DEPTH-1 bytes).
// A receive transaction (tuser[0]=0) pushes its byte into the port's ring or drops
// it when full; a poll (tuser[0]=1) pops from the current port and moves on to the
// next port once the last byte received on every port is nonzero and the last byte
// sent is CR or LF. Every transaction returns exactly one result. The front end
// holds the ring pointers and answers full/empty at once; the back end holds the
// byte store, whose read is registered. Receives are taken one per cycle while the
// two-entry command queue has room and no poll is pending. A poll closes the input
// until its result is registered, because the next poll needs the rotated port.
// The byte store is not cleared after reset; only slots already written are ever
// read.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_port_line_merge_fifo_core_defines.svh"
module multi_port_line_merge_fifo_core #(
    parameter int DEPTH = mplm_pkg::DEPTH_DEFAULT,
    parameter int PORTS = mplm_pkg::PORTS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [0] req_type, [1] port
    input  wire logic [7:0]  s_tdata,   // [7:0] data
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tuser,   // [0] accepted
    output logic [23:0]      m_tdata    // [7:0] out_byte, [13:8] out_port_char,
                                        // [22:14] free_space, [23] current_port
);
    import mplm_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int PW = $clog2(PORTS);
    localparam int AW = PW + IW;
    localparam int QW = AW + $bits(cmd_t);

    logic          q_push, q_in_ready, q_pop, q_valid;
    cmd_t          f_cmd, b_cmd;
    logic [AW-1:0] f_addr, b_addr;
    logic [QW-1:0] q_out;
    logic [PW-1:0] poll_port;
    logic          poll_done, poll_pending;

    mplm_front #(
        .DEPTH(DEPTH),
        .PORTS(PORTS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .q_in_ready  (q_in_ready),
        .q_push      (q_push),
        .q_cmd       (f_cmd),
        .q_addr      (f_addr),
        .poll_port   (poll_port),
        .poll_done   (poll_done),
        .poll_pending(poll_pending)
    );

    mplm_queue #(
        .W(QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_push  (q_push),
        .in_ready (q_in_ready),
        .in_data  ({f_addr, f_cmd}),
        .out_pop  (q_pop),
        .out_valid(q_valid),
        .out_data (q_out)
    );

    assign b_addr = q_out[QW-1:$bits(cmd_t)];
    assign b_cmd  = q_out[$bits(cmd_t)-1:0];

    mplm_back #(
        .DEPTH(DEPTH),
        .PORTS(PORTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (b_cmd),
        .q_addr   (b_addr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .poll_port(poll_port),
        .poll_done(poll_done)
    );

    `MPLM_ASSERT_IMP(a_queue_no_overflow, aclk, aresetn, q_push, q_in_ready)
    `MPLM_ASSERT_IMP(a_single_poll, aclk, aresetn, s_tvalid && s_tready && s_tuser[0], !poll_pending)
    `MPLM_ASSERT_NXT(a_poll_tracked, aclk, aresetn, s_tvalid && s_tready && s_tuser[0], poll_pending)
    `MPLM_ASSERT_IMP(a_no_byte_unless_sent, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)

endmodule
`default_nettype wire

// ----- sv/mplm_queue.sv -----
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module mplm_queue #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_push,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    input  wire logic         out_pop,
    output logic              out_valid,
    output logic [W-1:0]      out_data
);
    import mplm_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign in_ready  = (count_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (in_push && !out_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!in_push && out_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// ----- sv/mplm_front.sv -----
// Front end: accepts transactions, owns the ring pointers, issues commands.
`timescale 1ns / 1ps
`default_nettype none
module mplm_front #(
    parameter int DEPTH = mplm_pkg::DEPTH_DEFAULT,
    parameter int PORTS = mplm_pkg::PORTS_DEFAULT,
    localparam int IW = $clog2(DEPTH),
    localparam int PW = $clog2(PORTS),
    localparam int AW = PW + IW
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    s_tuser,   // [0] req_type, [1] port
    input  wire logic [7:0]    s_tdata,   // [7:0] data
    input  wire logic          q_in_ready,
    output logic               q_push,
    output mplm_pkg::cmd_t     q_cmd,
    output logic [AW-1:0]      q_addr,
    input  wire logic [PW-1:0] poll_port,
    input  wire logic          poll_done,
    output logic               poll_pending
);
    import mplm_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
    localparam logic [IW:0]   DEPTH_M1 = (IW + 1)'(DEPTH - 1);

    logic [IW-1:0] wr_idx_reg [PORTS];
    logic [IW-1:0] wr_idx_next [PORTS];
    logic [IW-1:0] rd_idx_reg [PORTS];
    logic [IW-1:0] rd_idx_next [PORTS];
    logic          poll_pending_reg, poll_pending_next;

    logic          is_poll, fire, acc;
    logic [PW-1:0] sel;
    logic [IW-1:0] cur_w, cur_r, w_new, r_new, w_inc, r_inc;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [FREE_W-1:0] free_of(input logic [IW-1:0] w,
                                                 input logic [IW-1:0] r);
        logic [IW:0] used;
        used = (w >= r) ? ({1'b0, w} - {1'b0, r}) : ({1'b0, w} + DEPTH_W - {1'b0, r});
        return FREE_W'(DEPTH_M1 - used);
    endfunction

    assign is_poll      = s_tuser[0];
    // one poll in flight at a time: the next poll needs the rotated port
    assign s_tready     = q_in_ready && !poll_pending_reg;
    assign fire         = s_tvalid && s_tready;
    assign q_push       = fire;
    assign poll_pending = poll_pending_reg;

    always_comb begin
        sel   = is_poll ? poll_port : PW'(s_tuser[1]);
        cur_w = wr_idx_reg[sel];
        cur_r = rd_idx_reg[sel];
        w_inc = next_slot(cur_w);
        r_inc = next_slot(cur_r);
        w_new = cur_w;
        r_new = cur_r;
        if (is_poll) begin
            acc    = (cur_w != cur_r);
            r_new  = acc ? r_inc : cur_r;
            q_addr = {sel, cur_r};
        end else begin
            acc    = (w_inc != cur_r);
            w_new  = acc ? w_inc : cur_w;
            q_addr = {sel, cur_w};
        end
        q_cmd.is_poll    = is_poll;
        q_cmd.accepted   = acc;
        q_cmd.data       = s_tdata;
        q_cmd.free_space = free_of(w_new, r_new);

        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        if (fire) begin
            wr_idx_next[sel] = w_new;
            rd_idx_next[sel] = r_new;
        end

        poll_pending_next = poll_pending_reg;
        if (fire && is_poll) begin
            poll_pending_next = 1'b1;
        end else if (poll_done) begin
            poll_pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PORTS; i++) begin
                wr_idx_reg[i] <= '0;
                rd_idx_reg[i] <= '0;
            end
            poll_pending_reg <= 1'b0;
        end else begin
            wr_idx_reg       <= wr_idx_next;
            rd_idx_reg       <= rd_idx_next;
            poll_pending_reg <= poll_pending_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/mplm_back.sv -----
// Back end: byte store, line tracking, port rotation and result register.
`timescale 1ns / 1ps
`default_nettype none
module mplm_back #(
    parameter int DEPTH = mplm_pkg::DEPTH_DEFAULT,
    parameter int PORTS = mplm_pkg::PORTS_DEFAULT,
    localparam int IW = $clog2(DEPTH),
    localparam int PW = $clog2(PORTS),
    localparam int AW = PW + IW
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire mplm_pkg::cmd_t  q_cmd,
    input  wire logic [AW-1:0]   q_addr,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic                 m_tuser,   // [0] accepted
    output logic [23:0]          m_tdata,   // [7:0] out_byte, [13:8] out_port_char,
                                            // [22:14] free_space, [23] current_port
    output logic [PW-1:0]        poll_port,
    output logic                 poll_done
);
    import mplm_pkg::*;

    localparam int MEM_DEPTH = PORTS << IW;

    logic [7:0]    mem [MEM_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          stg_valid_reg;
    cmd_t          stg_cmd_reg;
    logic [AW-1:0] stg_addr_reg;
    logic [7:0]    last_rx_reg [PORTS];
    logic [7:0]    last_sent_reg, last_sent_next;
    logic [PW-1:0] poll_port_reg, poll_port_next;
    logic          m_valid_reg;
    logic          m_tuser_reg;
    logic [23:0]   m_tdata_reg;

    logic          out_free, stg_adv, all_seen, rotate;
    logic [PW-1:0] stg_port;
    logic [7:0]    res_byte, res_char;

    assign out_free  = !m_valid_reg || m_tready;
    assign stg_adv   = stg_valid_reg && out_free;
    assign q_pop     = q_valid && (!stg_valid_reg || out_free);
    assign stg_port  = stg_addr_reg[AW-1:IW];
    assign poll_done = stg_adv && stg_cmd_reg.is_poll;
    assign poll_port = poll_port_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        all_seen = 1'b1;
        for (int i = 0; i < PORTS; i++) begin
            if (last_rx_reg[i] == 8'd0) begin
                all_seen = 1'b0;
            end
        end
        res_byte       = 8'd0;
        res_char       = CH_ZERO;
        last_sent_next = last_sent_reg;
        poll_port_next = poll_port_reg;
        rotate         = 1'b0;
        if (stg_cmd_reg.is_poll) begin
            if (stg_cmd_reg.accepted) begin
                res_byte       = rd_data_reg;
                res_char       = CH_ZERO + 8'(poll_port_reg) + 8'd1;
                last_sent_next = rd_data_reg;
            end
            // a failed poll still checks rotation against the older last byte
            rotate = all_seen && (last_sent_next == CH_CR || last_sent_next == CH_LF);
            if (rotate) begin
                poll_port_next = (poll_port_reg == PW'(PORTS - 1)) ? '0
                                                                   : poll_port_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_sent_reg <= 8'd0;
            poll_port_reg <= '0;
            for (int i = 0; i < PORTS; i++) begin
                last_rx_reg[i] <= 8'd0;
            end
        end else begin
            if (q_pop) begin
                stg_valid_reg <= 1'b1;
            end else if (stg_adv) begin
                stg_valid_reg <= 1'b0;
            end
            if (stg_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (stg_adv) begin
                last_sent_reg <= last_sent_next;
                poll_port_reg <= poll_port_next;
                if (!stg_cmd_reg.is_poll) begin
                    last_rx_reg[stg_port] <= stg_cmd_reg.data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            stg_cmd_reg  <= q_cmd;
            stg_addr_reg <= q_addr;
            if (q_cmd.accepted && !q_cmd.is_poll) begin
                mem[q_addr] <= q_cmd.data;
            end
            if (q_cmd.accepted && q_cmd.is_poll) begin
                rd_data_reg <= mem[q_addr];
            end
        end
        if (stg_adv) begin
            m_tuser_reg <= stg_cmd_reg.accepted;
            m_tdata_reg <= {poll_port_next[0], stg_cmd_reg.free_space,
                            res_char[5:0], res_byte};
        end
    end

endmodule
`default_nettype wire
